@@ sv/tcw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Command codes, default geometry, controller/datapath command and status.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLS_DEF = 80;
  localparam int ROWS_DEF = 25;

  localparam logic [2:0] CMD_PUT   = 3'd0;
  localparam logic [2:0] CMD_GOTO  = 3'd1;
  localparam logic [2:0] CMD_LEFT  = 3'd2;
  localparam logic [2:0] CMD_RIGHT = 3'd3;
  localparam logic [2:0] CMD_CLEAR = 3'd4;
  localparam logic [2:0] CMD_WRITE = 3'd5;
  localparam logic [2:0] CMD_READ  = 3'd6;

  localparam logic [7:0] CH_BLANK = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_BS    = 8'h08;

  localparam logic [0:0] REG_FORE = 1'b0;
  localparam logic [0:0] REG_BACK = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input item, decode it
    logic exec;       // apply cursor update and single cell access
    logic fill_start; // start sweep (clear from 0 or scroll)
    logic fill_step;  // advance the sweep by one step
    logic rd_issue;   // issue read of cell
    logic out_load;   // latch result
  } tcw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_clear;
    logic need_scroll;
    logic need_read;
    logic fill_done;
  } tcw_sts_t;

endpackage
`default_nettype wire

@@ sv/text_console_writer.sv @@
`default_nettype none
// Clear and scroll are sweeps over the cell store, which has a single
// write port. A new transaction is taken only once the previous one has
// handed its result to the output register.
// Reset: cursor home, colors white on black; the screen is swept to blank
// before the first transaction is taken.
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console with cursor and cell store
// Streaming command in, cursor position and read cell out.
// ----------------------------------------------------------------------------
module text_console_writer #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [2:0] cmd, [10:3] char_code, [20:11] col, [30:21] row,
  // [42:31] move_count, [50:43] cell_attr
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [10:0] cursor_pos, [26:11] cell_data
  output logic [31:0]      out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_data
);

  logic [3:0] fore_r, back_r;
  logic       boot_r;   // power-up clear pending
  logic       ovalid_r;
  logic       busy;
  tcw_pkg::tcw_cmd_t cmd, cmd_q;
  tcw_pkg::tcw_sts_t sts;
  logic [10:0] pos;
  logic [15:0] rd_cell;
  logic        in_fire;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fore_r <= 4'hF; back_r <= 4'h0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tcw_pkg::REG_FORE: fore_r <= cfg_data;
        tcw_pkg::REG_BACK: back_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = !busy && !boot_r;
  assign in_fire = in_tvalid && in_tready;

  tcw_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .out_free(!ovalid_r || out_tready), .sts(sts), .busy(busy), .cmd(cmd)
  );

  // boot: run a clear sweep with white-on-black blanks
  logic boot_go_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_r <= 1'b1; boot_go_r <= 1'b1;
    end else begin
      boot_go_r <= 1'b0;
      if (boot_r && !boot_go_r && sts.fill_done) boot_r <= 1'b0;
    end
  end

  always_comb begin
    cmd_q = cmd;
    if (boot_r) begin
      cmd_q = '0;
      cmd_q.fill_start = boot_go_r;
      cmd_q.fill_step  = !boot_go_r;
    end
  end

  tcw_dp #(.COLS(COLS), .ROWS(ROWS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_q), .sts(sts),
    .in_cmd(in_tdata[2:0]), .in_char(in_tdata[10:3]), .in_col(in_tdata[20:11]),
    .in_row(in_tdata[30:21]), .in_cnt(in_tdata[42:31]), .in_attr(in_tdata[50:43]),
    .fore(boot_r ? 4'hF : fore_r), .back(boot_r ? 4'h0 : back_r),
    .out_pos(pos), .out_cell(rd_cell)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) ovalid_r <= 1'b0;
    else if (cmd.out_load) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, rd_cell, pos};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("accept while busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> busy) else $error("result without item");
  a_boot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    boot_r |-> !busy) else $error("item during power-up clear");

endmodule
`default_nettype wire

@@ sv/tcw_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl: command sequencer
// Steps each item through decode, execute, an optional sweep or cell read, and result load.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          out_free,
  input  tcw_pkg::tcw_sts_t  sts,
  output logic               busy,
  output tcw_pkg::tcw_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DEC   = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_FILL  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.exec = 1'b1;
        if (sts.need_clear || sts.need_scroll) begin
          cmd.fill_start = 1'b1;
          state_nxt = S_FILL;
        end else if (sts.need_read) begin
          cmd.rd_issue = 1'b1;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_done) state_nxt = S_DONE;
      end
      S_RD: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ sv/tcw_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_dp: cursor arithmetic, cell store and result register
// Cell store is one memory with one write and one registered read port.
// ----------------------------------------------------------------------------
module tcw_dp #(
  parameter int COLS = tcw_pkg::COLS_DEF,
  parameter int ROWS = tcw_pkg::ROWS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  tcw_pkg::tcw_cmd_t  cmd,
  output tcw_pkg::tcw_sts_t  sts,
  input  wire logic [2:0]    in_cmd,
  input  wire logic [7:0]    in_char,
  input  wire logic [9:0]    in_col,
  input  wire logic [9:0]    in_row,
  input  wire logic [11:0]   in_cnt,
  input  wire logic [7:0]    in_attr,
  input  wire logic [3:0]    fore,
  input  wire logic [3:0]    back,
  output logic [10:0]        out_pos,
  output logic [15:0]        out_cell
);

  localparam int CELLS = COLS * ROWS;
  localparam int CW = $clog2(COLS);
  localparam int RW = $clog2(ROWS + 1);
  localparam int AW = $clog2(CELLS);
  localparam int PW = $clog2(CELLS + COLS + 4096);

  // item registers
  logic [2:0]  op_r;
  logic [7:0]  ch_r, attr_r;
  logic signed [9:0] c_r, r_r;
  logic [11:0] n_r;

  logic [CW-1:0] ccol_r;
  logic [RW-1:0] crow_r;
  logic [PW-1:0] pos_r;   // linear cursor, kept in step with col/row

  logic [AW-1:0] fptr_r;  // sweep write pointer
  logic          scroll_r;
  logic          rd_phase_r; // sweep: read then write, alternating
  logic [15:0]   mem [CELLS];
  logic [15:0]   rdata_r;
  logic          rd_ok_r;
  logic [15:0]   cell_r;
  logic [10:0]   pos_out_r;

  logic [15:0] blank;
  assign blank = {back, fore, tcw_pkg::CH_BLANK};

  logic on_scr;
  assign on_scr = !c_r[9] && !r_r[9] && (c_r < 10'(COLS)) && (r_r < 10'(ROWS));
  logic [AW-1:0] xy_addr;
  assign xy_addr = AW'(r_r[RW-1:0] * COLS) + AW'(c_r[CW-1:0]);
  logic [AW-1:0] cur_addr;
  assign cur_addr = AW'(pos_r);

  // decode results (combinational, from registered item)
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [CW-1:0] ncol;
  logic [RW-1:0] nrow;
  logic [PW-1:0] npos;
  logic          scroll_nd;
  logic [PW-1:0] lin_tgt;
  logic          lin_use;

  always_comb begin
    wr_en = 1'b0; wr_addr = cur_addr; wr_data = blank;
    ncol = ccol_r; nrow = crow_r; npos = pos_r; scroll_nd = 1'b0;
    lin_tgt = pos_r; lin_use = 1'b0;
    case (op_r)
      tcw_pkg::CMD_PUT: begin
        if (ch_r == tcw_pkg::CH_NL) begin
          ncol = '0; nrow = crow_r + 1'b1;
        end else if (ch_r == tcw_pkg::CH_CR) begin
          ncol = '0;
        end else if (ch_r == tcw_pkg::CH_BS) begin
          if (pos_r != '0) begin
            wr_en = 1'b1; wr_addr = AW'(pos_r - 1'b1);
            if (ccol_r != '0) ncol = ccol_r - 1'b1;
            else begin ncol = CW'(COLS - 1); nrow = crow_r - 1'b1; end
          end
        end else begin
          wr_en = 1'b1; wr_data = {back, fore, ch_r};
          if (ccol_r == CW'(COLS - 1)) begin ncol = '0; nrow = crow_r + 1'b1; end
          else ncol = ccol_r + 1'b1;
        end
        if (nrow == RW'(ROWS)) begin scroll_nd = 1'b1; nrow = RW'(ROWS - 1); end
        npos = PW'(nrow * COLS) + PW'(ncol);
      end
      tcw_pkg::CMD_GOTO: begin
        ncol = c_r[9] ? '0 : (c_r >= 10'(COLS)) ? CW'(COLS - 1) : c_r[CW-1:0];
        nrow = r_r[9] ? '0 : (r_r >= 10'(ROWS)) ? RW'(ROWS - 1) : r_r[RW-1:0];
        npos = PW'(nrow * COLS) + PW'(ncol);
      end
      tcw_pkg::CMD_LEFT: begin
        lin_use = 1'b1;
        lin_tgt = (PW'(n_r) >= pos_r) ? '0 : pos_r - PW'(n_r);
      end
      tcw_pkg::CMD_RIGHT: begin
        lin_use = 1'b1;
        lin_tgt = (pos_r + PW'(n_r) >= PW'(CELLS - 1)) ? PW'(CELLS - 1)
                  : pos_r + PW'(n_r);
      end
      tcw_pkg::CMD_CLEAR: begin
        ncol = '0; nrow = '0; npos = '0;
      end
      tcw_pkg::CMD_WRITE: begin
        wr_en = on_scr; wr_addr = xy_addr; wr_data = {attr_r, ch_r};
      end
      default: ;
    endcase
  end

  // linear to row/col: a compare chain over the rows, one compare
  // per row start, finds the row with no divide; a small compare chain
  // is cheap enough as a reciprocal-free table over rows.
  logic [RW-1:0] lrow;
  logic [CW-1:0] lcol;
  always_comb begin
    lrow = '0;
    for (int k = 1; k < ROWS; k++)
      if (lin_tgt >= PW'(k * COLS)) lrow = RW'(k);
    lcol = CW'(lin_tgt - PW'(lrow * COLS));
  end

  // sweep: clear writes blank to every cell; scroll copies row below
  // (read a cell, then write it in the cycle after) and blanks the last row
  logic [AW-1:0] src;
  assign src = fptr_r + AW'(COLS);
  logic in_last;
  assign in_last = fptr_r >= AW'(CELLS - COLS);

  assign sts.need_clear  = (op_r == tcw_pkg::CMD_CLEAR);
  assign sts.need_scroll = scroll_nd;
  assign sts.need_read   = (op_r == tcw_pkg::CMD_READ);
  assign sts.fill_done   = (fptr_r == AW'(CELLS - 1)) &&
                           (!scroll_r || in_last || !rd_phase_r);

  logic          m_we;
  logic [AW-1:0] m_wa, m_ra;
  logic [15:0]   m_wd;
  always_comb begin
    m_we = 1'b0; m_wa = wr_addr; m_wd = wr_data; m_ra = xy_addr;
    if (cmd.exec) m_we = wr_en;
    if (cmd.fill_step) begin
      m_wa = fptr_r; m_wd = blank; m_ra = src;
      if (!scroll_r || in_last) m_we = 1'b1;
      else if (!rd_phase_r) begin m_we = 1'b1; m_wd = rdata_r; end
    end
  end

  always_ff @(posedge clk) begin
    if (m_we) mem[m_wa] <= m_wd;
    rdata_r <= mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_cmd; ch_r <= in_char; c_r <= in_col; r_r <= in_row;
      n_r <= in_cnt; attr_r <= in_attr;
    end
    if (cmd.rd_issue) rd_ok_r <= on_scr;
    if (cmd.out_load) begin
      pos_out_r <= 11'(pos_r);
      cell_r <= (op_r == tcw_pkg::CMD_READ && rd_ok_r) ? rdata_r : 16'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccol_r <= '0; crow_r <= '0; pos_r <= '0;
      fptr_r <= '0; scroll_r <= 1'b0; rd_phase_r <= 1'b1;
    end else begin
      if (cmd.exec) begin
        if (lin_use) begin
          ccol_r <= lcol; crow_r <= lrow; pos_r <= lin_tgt;
        end else begin
          ccol_r <= ncol; crow_r <= nrow; pos_r <= npos;
        end
      end
      if (cmd.fill_start) begin
        fptr_r <= '0; scroll_r <= scroll_nd; rd_phase_r <= 1'b1;
      end else if (cmd.fill_step) begin
        if (scroll_r && !in_last) begin
          rd_phase_r <= !rd_phase_r;
          if (!rd_phase_r && fptr_r != AW'(CELLS - 1)) fptr_r <= fptr_r + 1'b1;
        end else if (fptr_r != AW'(CELLS - 1)) begin
          fptr_r <= fptr_r + 1'b1;
        end
      end
    end
  end

  assign out_pos  = pos_out_r;
  assign out_cell = cell_r;

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the text console writer
// Drives console commands (printable text, control characters, cursor moves,
// clears, direct cell writes and reads) through the command stream, predicts
// the cursor position and read-back cell of every transaction from a shadow
// screen, and compares each result in order.
// ----------------------------------------------------------------------------

class console_scoreboard;
  localparam int NCOLS = 80;
  localparam int NROWS = 25;
  localparam int NCELLS = NCOLS * NROWS;

  logic [15:0] shadow_cells [NCELLS];
  int unsigned cur_col, cur_row;
  logic [3:0] fore, back;
  logic [10:0] exp_pos_q [$];
  logic [15:0] exp_cell_q [$];
  int errors;
  int checked;

  function void init();
    for (int i = 0; i < NCELLS; i++) shadow_cells[i] = 16'h0F20;
    cur_col = 0;
    cur_row = 0;
    fore = 4'hF;
    back = 4'h0;
    errors = 0;
    checked = 0;
  endfunction

  function void set_reg(logic idx, logic [3:0] val);
    if (idx == tcw_pkg::REG_FORE) fore = val;
    else back = val;
  endfunction

  function logic [15:0] blank_cell();
    return {back, fore, tcw_pkg::CH_BLANK};
  endfunction

  function void scroll_up();
    if (cur_row < NROWS) return;
    for (int i = 0; i + NCOLS < NCELLS; i++) shadow_cells[i] = shadow_cells[i + NCOLS];
    for (int i = NCELLS - NCOLS; i < NCELLS; i++) shadow_cells[i] = blank_cell();
    cur_row = NROWS - 1;
  endfunction

  function void put_char(logic [7:0] ch);
    if (ch == tcw_pkg::CH_NL) begin
      cur_col = 0;
      cur_row++;
    end else if (ch == tcw_pkg::CH_CR) begin
      cur_col = 0;
    end else if (ch == tcw_pkg::CH_BS) begin
      if (cur_col > 0) cur_col--;
      else if (cur_row > 0) begin
        cur_col = NCOLS - 1;
        cur_row--;
      end else return;
      shadow_cells[cur_row * NCOLS + cur_col] = blank_cell();
      return;
    end else begin
      shadow_cells[cur_row * NCOLS + cur_col] = {back, fore, ch};
      cur_col++;
      if (cur_col >= NCOLS) begin
        cur_col = 0;
        cur_row++;
      end
    end
    scroll_up();
  endfunction

  // apply one accepted command and queue the expected result
  function void note_command(logic [55:0] d);
    logic [2:0] op;
    logic [7:0] ch;
    int c, r;
    int unsigned n, pos;
    logic [7:0] attr;
    logic [15:0] data;
    op = d[2:0];
    ch = d[10:3];
    c = 32'($signed(d[20:11]));
    r = 32'($signed(d[30:21]));
    n = 32'(d[42:31]);
    attr = d[50:43];
    data = 16'h0;
    pos = cur_row * NCOLS + cur_col;
    case (op)
      tcw_pkg::CMD_PUT: put_char(ch);
      tcw_pkg::CMD_GOTO: begin
        if (c < 0) c = 0;
        if (c >= NCOLS) c = NCOLS - 1;
        if (r < 0) r = 0;
        if (r >= NROWS) r = NROWS - 1;
        cur_col = c;
        cur_row = r;
      end
      tcw_pkg::CMD_LEFT: begin
        pos = (n >= pos) ? 0 : pos - n;
        cur_row = pos / NCOLS;
        cur_col = pos % NCOLS;
      end
      tcw_pkg::CMD_RIGHT: begin
        pos = (pos + n >= NCELLS - 1) ? NCELLS - 1 : pos + n;
        cur_row = pos / NCOLS;
        cur_col = pos % NCOLS;
      end
      tcw_pkg::CMD_CLEAR: begin
        for (int i = 0; i < NCELLS; i++) shadow_cells[i] = blank_cell();
        cur_col = 0;
        cur_row = 0;
      end
      tcw_pkg::CMD_WRITE:
        if (c >= 0 && c < NCOLS && r >= 0 && r < NROWS)
          shadow_cells[r * NCOLS + c] = {attr, ch};
      tcw_pkg::CMD_READ:
        if (c >= 0 && c < NCOLS && r >= 0 && r < NROWS)
          data = shadow_cells[r * NCOLS + c];
      default: ;
    endcase
    exp_pos_q.push_back(11'(cur_row * NCOLS + cur_col));
    exp_cell_q.push_back(data);
  endfunction

  function void check_result(logic [31:0] d);
    logic [10:0] ep;
    logic [15:0] ec;
    checked++;
    if (exp_pos_q.size() == 0) begin
      report("result with nothing expected", 0, 32'(d[10:0]));
      return;
    end
    ep = exp_pos_q.pop_front();
    ec = exp_cell_q.pop_front();
    if (d[10:0] !== ep) report("cursor_pos", 32'(ep), 32'(d[10:0]));
    if (d[26:11] !== ec) report("cell_data", 32'(ec), 32'(d[26:11]));
  endfunction

  function void report(string what, int unsigned exp_v, int unsigned got_v);
    errors++;
    $display("MISMATCH %s: expected %0h got %0h (result %0d)", what, exp_v, got_v, checked);
  endfunction

  function int pending();
    return exp_pos_q.size();
  endfunction
endclass

module tb;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [3:0] cfg_data = '0;

  console_scoreboard sb;
  bit calm;      // no stalls in the closing stretch
  int sent;

  always #10 clk = ~clk;

  text_console_writer i_dut (.*);

  initial begin
    #400ms;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random bursts with ready held low
  initial begin
    int burst;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        out_tready <= 1'b0;
        repeat (burst) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);

  function automatic logic [55:0] pack_cmd(logic [2:0] op, logic [7:0] ch, logic [9:0] c,
                                           logic [9:0] r, logic [11:0] n, logic [7:0] attr);
    return {5'b0, attr, n, r, c, ch, op};
  endfunction

  // valid stays up after a transaction; the next send or drain decides
  task automatic send_cmd(logic [55:0] d);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    sb.note_command(d);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_cmd();
    int k;
    logic [7:0] ch;
    logic [9:0] c, r;
    k = $urandom_range(0, 99);
    ch = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 2))
        0: ch = tcw_pkg::CH_NL;
        1: ch = tcw_pkg::CH_CR;
        default: ch = tcw_pkg::CH_BS;
      endcase
    end
    c = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 79));
    r = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 24));
    if (k < 50) send_cmd(pack_cmd(tcw_pkg::CMD_PUT, ch, 10'($urandom), 10'($urandom),
                                  12'($urandom), 8'($urandom)));
    else if (k < 58) send_cmd(pack_cmd(tcw_pkg::CMD_GOTO, ch, c, r, 12'($urandom), 8'($urandom)));
    else if (k < 64) send_cmd(pack_cmd(tcw_pkg::CMD_LEFT, ch, c, r,
                                       ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                                   : 12'($urandom_range(0, 90)),
                                       8'($urandom)));
    else if (k < 70) send_cmd(pack_cmd(tcw_pkg::CMD_RIGHT, ch, c, r,
                                       ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                                   : 12'($urandom_range(0, 90)),
                                       8'($urandom)));
    else if (k < 71) send_cmd(pack_cmd(tcw_pkg::CMD_CLEAR, ch, c, r, 12'($urandom), 8'($urandom)));
    else if (k < 80) send_cmd(pack_cmd(tcw_pkg::CMD_WRITE, ch, c, r, 12'($urandom), 8'($urandom)));
    else if (k < 99) send_cmd(pack_cmd(tcw_pkg::CMD_READ, ch, c, r, 12'($urandom), 8'($urandom)));
    else send_cmd(pack_cmd(3'd7, ch, c, r, 12'($urandom), 8'($urandom)));
  endtask

  initial begin
    sb = new();
    sb.init();
    calm = 1'b0;
    sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset screen, edges, control characters, scrolls
    send_cmd(pack_cmd(tcw_pkg::CMD_READ, 8'h00, 10'd0, 10'd0, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_READ, 8'h00, 10'd79, 10'd24, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 10'd0, 10'd0, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_PUT, 8'h00, 10'h3FF, 10'h3FF, 12'hFFF, 8'hFF));
    send_cmd(pack_cmd(tcw_pkg::CMD_PUT, 8'hFF, 10'h200, 10'h200, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_GOTO, 8'h00, 10'h200, 10'h1FF, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_GOTO, 8'h00, 10'h1FF, 10'h200, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_BS, 10'd0, 10'd0, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_CR, 10'd0, 10'd0, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_RIGHT, 8'h00, 10'd0, 10'd0, 12'hFFF, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_PUT, 8'h41, 10'd0, 10'd0, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_PUT, tcw_pkg::CH_NL, 10'd0, 10'd0, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_LEFT, 8'h00, 10'd0, 10'd0, 12'd5, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_LEFT, 8'h00, 10'd0, 10'd0, 12'hFFF, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_WRITE, 8'h5A, 10'd79, 10'd24, 12'd0, 8'hA5));
    send_cmd(pack_cmd(tcw_pkg::CMD_WRITE, 8'hFF, 10'd80, 10'd0, 12'd0, 8'hFF));
    send_cmd(pack_cmd(tcw_pkg::CMD_WRITE, 8'hFF, 10'h3FF, 10'd25, 12'd0, 8'hFF));
    send_cmd(pack_cmd(tcw_pkg::CMD_READ, 8'h00, 10'd79, 10'd24, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_READ, 8'h00, 10'h3FF, 10'd0, 12'd0, 8'h00));
    send_cmd(pack_cmd(3'd7, 8'hFF, 10'h3FF, 10'h3FF, 12'hFFF, 8'hFF));
    write_reg(tcw_pkg::REG_FORE, 4'h0);
    write_reg(tcw_pkg::REG_BACK, 4'hF);
    send_cmd(pack_cmd(tcw_pkg::CMD_CLEAR, 8'h00, 10'd0, 10'd0, 12'd0, 8'h00));
    send_cmd(pack_cmd(tcw_pkg::CMD_READ, 8'h00, 10'd40, 10'd12, 12'd0, 8'h00));

    // random phases, colors changed between them
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) calm = 1'b1;
      repeat (270) random_cmd();
      drain();  // sender holds off until all results are back
      write_reg(tcw_pkg::REG_FORE, (ph == 0) ? 4'hF : 4'($urandom));
      write_reg(tcw_pkg::REG_BACK, (ph == 0) ? 4'h0 : 4'($urandom));
    end

    drain();
    $display("Ran %0d commands: text with wraps and scrolls, control chars, moves,", sent);
    $display("clears, cell writes and reads, under several color settings.");
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
